>>> src/meiu_pkg.sv
// meiu_pkg: widths, fixed-point types, register indexes, controller states and
// saturation helpers for the mandelbrot escape iteration unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package meiu_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 27;
  localparam int INDEX_BITS = 12;
  localparam int ITER_BITS  = 24;

  // full product of two coordinates, and of an index by a coordinate
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int CPROD_BITS = INDEX_BITS + 1 + COORD_BITS;
  // sum of two non-negative squares
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_BITS-1:0]  wide_t;
  typedef logic signed [CPROD_BITS-1:0] cprod_t;
  typedef logic [ITER_BITS-1:0]         iter_t;
  typedef logic [INDEX_BITS-1:0]        index_t;
  typedef logic [MAG_BITS-1:0]          mag_t;

  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // four in the magnitude format; unreachable when two clamped squares cannot sum to it
  localparam bit   FOUR_OK = (FRAC_BITS + 2) < COORD_BITS;
  localparam mag_t FOUR    = FOUR_OK ? (mag_t'(1) << (FRAC_BITS + 2)) : '0;

  localparam coord_t X_LEFT_RST    = coord_t'(-268435456);
  localparam coord_t X_STEP_RST    = coord_t'(262144);
  localparam coord_t Y_LOWER_RST   = coord_t'(-268435456);
  localparam coord_t Y_STEP_RST    = coord_t'(262144);
  localparam iter_t  MAX_ITERS_RST = iter_t'(255);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_X_LEFT    = 3'd0,
    CFG_X_STEP    = 3'd1,
    CFG_Y_LOWER   = 3'd2,
    CFG_Y_STEP    = 3'd3,
    CFG_MAX_ITERS = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD_MUL,
    ST_COORD_ADD,
    ST_ITER_MUL,
    ST_ITER_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_pixel;
    logic coord_mul;
    logic coord_add;
    logic iter_mul;
    logic iter_step;
    logic finish;
  } meiu_cmd_t;

  typedef struct packed {
    logic stop;
  } meiu_sts_t;

  // clamp a wide signed value into the coordinate range
  function automatic coord_t sat_wide(input wide_t v);
    logic [PROD_BITS-COORD_BITS:0] top;
    top = v[PROD_BITS-1:COORD_BITS-1];
    if ((top == '0) || (top == '1)) begin
      return v[COORD_BITS-1:0];
    end else if (v[PROD_BITS-1]) begin
      return CMIN;
    end else begin
      return CMAX;
    end
  endfunction

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    wide_t s;
    s = wide_t'(a) + wide_t'(b);
    return sat_wide(s);
  endfunction

endpackage

`default_nettype wire

>>> src/mandelbrot_escape_iteration_unit.sv
// mandelbrot_escape_iteration_unit: top level, joins the sequencer and the
// datapath and presents the request, result and configuration ports
// depends on meiu_pkg, meiu_ctrl, meiu_datapath
`timescale 1ns / 1ps
`default_nettype none

// One pixel at a time. A request is taken when start is high and busy is low;
// busy then stays high until the result has been shown. A pixel runs point
// set-up (the coordinate multiply, then the add that forms c) and then the
// iteration loop: each step forms the three products of z in ST_ITER_MUL, then
// clamps, tests |z|^2 against four and updates z in ST_ITER_EVAL; a final
// multiply and test ends the loop. The result is on the out_ ports for the
// single cycle that out_valid is high and cannot be held off; the next request
// can be taken in the cycle after. Configuration writes are always ready and
// belong in the gaps where busy is low.

module mandelbrot_escape_iteration_unit import meiu_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [INDEX_BITS-1:0]   in_col_index,
  input  wire logic [INDEX_BITS-1:0]   in_row_index,
  input  wire logic                    in_last_pixel,
  output logic                         out_valid,
  output logic [ITER_BITS-1:0]         out_iteration_count,
  output logic                         out_escaped,
  output logic [INDEX_BITS-1:0]        out_col_out,
  output logic [INDEX_BITS-1:0]        out_row_out,
  output logic                         out_last_out,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [COORD_BITS-1:0]   cfg_data
);

  meiu_cmd_t cmd;
  meiu_sts_t sts;

  assign cfg_ready = 1'b1;

  meiu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  meiu_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_col_index        (in_col_index),
    .in_row_index        (in_row_index),
    .in_last_pixel       (in_last_pixel),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_iteration_count (out_iteration_count),
    .out_escaped         (out_escaped),
    .out_col_out         (out_col_out),
    .out_row_out         (out_row_out),
    .out_last_out        (out_last_out)
  );

endmodule

`default_nettype wire

>>> src/meiu_ctrl.sv
// meiu_ctrl: sequencer for one pixel: coordinate set-up, then the
// multiply / evaluate iteration loop, then a one-cycle result strobe
// depends on meiu_pkg
`timescale 1ns / 1ps
`default_nettype none

module meiu_ctrl import meiu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  output logic           out_valid,
  output meiu_cmd_t      cmd,
  input  wire meiu_sts_t sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_pixel = 1'b1;
          state_nxt      = ST_COORD_MUL;
        end
      end
      ST_COORD_MUL: begin
        cmd.coord_mul = 1'b1;
        state_nxt     = ST_COORD_ADD;
      end
      ST_COORD_ADD: begin
        cmd.coord_add = 1'b1;
        state_nxt     = ST_ITER_MUL;
      end
      ST_ITER_MUL: begin
        cmd.iter_mul = 1'b1;
        state_nxt    = ST_ITER_EVAL;
      end
      ST_ITER_EVAL: begin
        if (sts.stop) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          cmd.iter_step = 1'b1;
          state_nxt     = ST_ITER_MUL;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/meiu_datapath.sv
// meiu_datapath: configuration registers, point set-up, the z = z^2 + c
// update with saturating fixed point, and the result registers
// depends on meiu_pkg
`timescale 1ns / 1ps
`default_nettype none

module meiu_datapath import meiu_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [COORD_BITS-1:0]   cfg_data,
  input  wire index_t                  in_col_index,
  input  wire index_t                  in_row_index,
  input  wire logic                    in_last_pixel,
  input  wire meiu_cmd_t               cmd,
  output meiu_sts_t                    sts,
  output iter_t                        out_iteration_count,
  output logic                         out_escaped,
  output index_t                       out_col_out,
  output index_t                       out_row_out,
  output logic                         out_last_out
);

  coord_t x_left_r, x_step_r, y_lower_r, y_step_r;
  iter_t  max_iters_r;

  index_t col_r, row_r;
  logic   last_r;
  cprod_t xprod_r, yprod_r;
  coord_t cr_r, ci_r;
  coord_t zr_r, zi_r;
  wide_t  pcross_r, prr_r, pii_r;
  iter_t  count_r;
  logic   escaped_r;

  coord_t cross_s, zr2, zi2, diff, zr_nxt, zi_nxt;
  mag_t   mag;
  logic   mag_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_left_r    <= X_LEFT_RST;
      x_step_r    <= X_STEP_RST;
      y_lower_r   <= Y_LOWER_RST;
      y_step_r    <= Y_STEP_RST;
      max_iters_r <= MAX_ITERS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LEFT:    x_left_r    <= coord_t'(cfg_data);
        CFG_X_STEP:    x_step_r    <= coord_t'(cfg_data);
        CFG_Y_LOWER:   y_lower_r   <= coord_t'(cfg_data);
        CFG_Y_STEP:    y_step_r    <= coord_t'(cfg_data);
        CFG_MAX_ITERS: max_iters_r <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // squares and cross term of the current z, each clamped after the shift, then the next z and the stop test
  always_comb begin
    cross_s = sat_wide(pcross_r >>> (FRAC_BITS - 1));
    zr2     = sat_wide(prr_r >>> FRAC_BITS);
    zi2     = sat_wide(pii_r >>> FRAC_BITS);
    zi_nxt  = sat_add(cross_s, ci_r);
    diff    = sat_add(zr2, -zi2);
    zr_nxt  = sat_add(diff, cr_r);
    mag     = {1'b0, zr2} + {1'b0, zi2};
    mag_hit = FOUR_OK && (mag >= FOUR);
    sts.stop = mag_hit || (count_r >= max_iters_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      col_r  <= in_col_index;
      row_r  <= in_row_index;
      last_r <= in_last_pixel;
    end
    if (cmd.coord_mul) begin
      xprod_r <= signed'({1'b0, col_r}) * x_step_r;
      yprod_r <= signed'({1'b0, row_r}) * y_step_r;
    end
    if (cmd.coord_add) begin
      cr_r    <= sat_add(x_left_r, sat_wide(wide_t'(xprod_r)));
      ci_r    <= sat_add(y_lower_r, sat_wide(wide_t'(yprod_r)));
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
    end
    if (cmd.iter_mul) begin
      pcross_r <= zr_r * zi_r;
      prr_r    <= zr_r * zr_r;
      pii_r    <= zi_r * zi_r;
    end
    if (cmd.iter_step) begin
      zr_r    <= zr_nxt;
      zi_r    <= zi_nxt;
      count_r <= count_r + iter_t'(1);
    end
    if (cmd.finish) begin
      escaped_r <= mag_hit;
    end
  end

  assign out_iteration_count = count_r;
  assign out_escaped         = escaped_r;
  assign out_col_out         = col_r;
  assign out_row_out         = row_r;
  assign out_last_out        = last_r;

endmodule

`default_nettype wire

>>> dv/tb_mandelbrot_escape_iteration_unit.sv
`timescale 1ns / 1ps
// tb_mandelbrot_escape_iteration_unit: self-checking bench for the escape-time unit,
// a queue-fed request driver, a strobe monitor and a bit-true fixed-point predictor
// depends on meiu_pkg and mandelbrot_escape_iteration_unit

module tb_mandelbrot_escape_iteration_unit;
  import meiu_pkg::*;

  localparam longint Q_ONE        = longint'(1) << FRAC_BITS;
  localparam longint FOUR_Q       = longint'(4) << FRAC_BITS;
  localparam int     CFG_IDX_SPAN = 1 << CFG_IDX_BITS;
  localparam int     MAX_REPORTS  = 40;
  localparam int     PHASES       = 13;
  localparam int     PHASE_PIXELS = 102;
  localparam int     DRAIN_CYCLES = 64;

  typedef enum int {MIX_WINDOW, MIX_DEEP, MIX_EXTREME, MIX_FAST_ESCAPE} phase_mix_t;

  typedef struct packed {
    index_t col;
    index_t row;
    logic   last;
  } pixel_req_t;

  typedef struct packed {
    iter_t  count;
    logic   escaped;
    index_t col;
    index_t row;
    logic   last;
  } pixel_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  index_t                  in_col_index = '0;
  index_t                  in_row_index = '0;
  logic                    in_last_pixel = 1'b0;
  logic                    out_valid;
  iter_t                   out_iteration_count;
  logic                    out_escaped;
  index_t                  out_col_out;
  index_t                  out_row_out;
  logic                    out_last_out;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0]   cfg_data = '0;

  // predictor copy of the register file
  coord_t x_left_q    = X_LEFT_RST;
  coord_t x_step_q    = X_STEP_RST;
  coord_t y_lower_q   = Y_LOWER_RST;
  coord_t y_step_q    = Y_STEP_RST;
  iter_t  max_iters_q = MAX_ITERS_RST;

  pixel_req_t    pending_pixels[$];
  pixel_result_t predicted_pixels[$];
  int            sent_count = 0;
  int            taken_count = 0;
  int            error_count = 0;
  int unsigned   sender_idle_pct = 0;

  mandelbrot_escape_iteration_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_col_index        (in_col_index),
    .in_row_index        (in_row_index),
    .in_last_pixel       (in_last_pixel),
    .out_valid           (out_valid),
    .out_iteration_count (out_iteration_count),
    .out_escaped         (out_escaped),
    .out_col_out         (out_col_out),
    .out_row_out         (out_row_out),
    .out_last_out        (out_last_out),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic coord_t clamp_coord(input longint v);
    if (v > longint'(CMAX)) begin
      return CMAX;
    end else if (v < longint'(CMIN)) begin
      return CMIN;
    end
    return coord_t'(v);
  endfunction

  function automatic pixel_result_t escape_time(input pixel_req_t px);
    pixel_result_t r;
    coord_t        cr, ci, zr, zi, zr2, zi2;
    longint        mag;
    int unsigned   n;
    cr = clamp_coord(longint'(x_left_q) +
                     longint'(clamp_coord(longint'(px.col) * longint'(x_step_q))));
    ci = clamp_coord(longint'(y_lower_q) +
                     longint'(clamp_coord(longint'(px.row) * longint'(y_step_q))));
    zr = '0;
    zi = '0;
    zr2 = '0;
    zi2 = '0;
    mag = 0;
    n = 0;
    while (mag < FOUR_Q && n < max_iters_q) begin
      // 2*zr*zi is one shift less; each product clamps before its sum
      zi = clamp_coord(longint'(clamp_coord((longint'(zr) * longint'(zi)) >>> (FRAC_BITS - 1)))
                       + longint'(ci));
      zr = clamp_coord(longint'(clamp_coord(longint'(zr2) - longint'(zi2))) + longint'(cr));
      zr2 = clamp_coord((longint'(zr) * longint'(zr)) >>> FRAC_BITS);
      zi2 = clamp_coord((longint'(zi) * longint'(zi)) >>> FRAC_BITS);
      mag = longint'(zr2) + longint'(zi2);
      n++;
    end
    r.count = iter_t'(n);
    r.escaped = (mag >= FOUR_Q);
    r.col = px.col;
    r.row = px.row;
    r.last = px.last;
    return r;
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(5))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3: return '1;
      4: return coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  // request driver: a new pixel only once the previous request has been taken
  always @(negedge clk) begin : drive_requests
    pixel_req_t px;
    if (rst_n && taken_count == sent_count) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        px = pending_pixels.pop_front();
        start <= 1'b1;
        in_col_index <= px.col;
        in_row_index <= px.row;
        in_last_pixel <= px.last;
        sent_count++;
      end else begin
        start <= 1'b0;
        in_col_index <= index_t'($urandom);
        in_row_index <= index_t'($urandom);
        in_last_pixel <= 1'($urandom);
      end
    end
  end

  always @(posedge clk) begin : check_results
    pixel_req_t    px;
    pixel_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_X_LEFT:    x_left_q = coord_t'(cfg_data);
          CFG_X_STEP:    x_step_q = coord_t'(cfg_data);
          CFG_Y_LOWER:   y_lower_q = coord_t'(cfg_data);
          CFG_Y_STEP:    y_step_q = coord_t'(cfg_data);
          CFG_MAX_ITERS: max_iters_q = cfg_data[ITER_BITS-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        px.col = in_col_index;
        px.row = in_row_index;
        px.last = in_last_pixel;
        predicted_pixels.push_back(escape_time(px));
        taken_count++;
      end
      if (out_valid) begin
        if (predicted_pixels.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t ns: result with none expected, expected nothing, got count %0d",
                     $time, out_iteration_count);
          end
        end else begin
          want = predicted_pixels.pop_front();
          check_field("iteration_count", want.count, out_iteration_count);
          check_field("escaped", want.escaped, out_escaped);
          check_field("col_out", want.col, out_col_out);
          check_field("row_out", want.row, out_row_out);
          check_field("last_out", want.last, out_last_out);
        end
      end
    end
  end

  task automatic queue_pixel(input index_t col, input index_t row, input logic last);
    pixel_req_t px;
    px.col = col;
    px.row = row;
    px.last = last;
    pending_pixels.push_back(px);
  endtask

  task automatic fill_random(input int n);
    for (int i = 0; i < n; i++) begin
      queue_pixel(index_t'($urandom), index_t'($urandom), $urandom_range(15) == 0);
    end
  endtask

  task automatic drain_requests();
    while (pending_pixels.size() != 0 || taken_count != sent_count ||
           predicted_pixels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [COORD_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_index <= CFG_IDX_BITS'($urandom);
    cfg_data <= $urandom;
  endtask

  task automatic program_all(input coord_t xl, input coord_t xs, input coord_t yl,
                             input coord_t ys, input logic [COORD_BITS-1:0] limit);
    write_reg(CFG_X_LEFT, xl);
    write_reg(CFG_X_STEP, xs);
    write_reg(CFG_Y_LOWER, yl);
    write_reg(CFG_Y_STEP, ys);
    write_reg(CFG_MAX_ITERS, limit);
  endtask

  initial begin : run_test
    int unsigned idle_mix[3];
    phase_mix_t  mix;
    bit          flip;
    idle_mix[0] = 0;
    idle_mix[1] = 51;
    idle_mix[2] = 33;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset window: corners, the origin, inside and outside points
    queue_pixel(0, 0, 1'b0);
    queue_pixel(4095, 4095, 1'b1);
    queue_pixel(1024, 1024, 1'b0);
    queue_pixel(0, 1024, 1'b1);
    queue_pixel(4095, 0, 1'b0);
    queue_pixel(0, 4095, 1'b1);
    queue_pixel(768, 1024, 1'b0);
    queue_pixel(1536, 1024, 1'b1);
    drain_requests();

    // zero limit, with junk above the 24 counter bits
    write_reg(CFG_MAX_ITERS, 32'hff00_0000);
    queue_pixel(1024, 1024, 1'b1);
    queue_pixel(0, 0, 1'b0);
    queue_pixel(4095, 4095, 1'b1);
    drain_requests();

    // limit of one: c = -2 escapes exactly on the final step
    write_reg(CFG_MAX_ITERS, 32'd1);
    queue_pixel(0, 1024, 1'b0);
    queue_pixel(1024, 1024, 1'b1);
    drain_requests();

    // saturating coordinates in both directions
    program_all(CMAX, CMAX, CMIN, CMIN, 32'd3);
    queue_pixel(4095, 4095, 1'b1);
    queue_pixel(0, 0, 1'b0);
    queue_pixel(1, 1, 1'b0);
    drain_requests();
    program_all(CMIN, CMAX, CMAX, CMIN, 32'd3);
    queue_pixel(4095, 4095, 1'b0);
    drain_requests();

    // unused register indexes must leave the registers alone
    for (int k = int'(CFG_MAX_ITERS) + 1; k < CFG_IDX_SPAN; k++) begin
      write_reg(CFG_IDX_BITS'(k), $urandom);
    end
    queue_pixel(2048, 2048, 1'b1);
    drain_requests();

    for (int p = 0; p < PHASES; p++) begin
      mix = (p == 4) ? MIX_FAST_ESCAPE : (p == 7) ? MIX_DEEP :
            (p % 4 == 2) ? MIX_EXTREME : MIX_WINDOW;
      flip = 1'($urandom);
      case (mix)
        MIX_WINDOW, MIX_DEEP: begin
          program_all(coord_t'(-longint'($urandom_range(5 * Q_ONE / 2, Q_ONE / 2))),
                      coord_t'($urandom_range(Q_ONE / 1024, Q_ONE / 8192)),
                      coord_t'(-longint'($urandom_range(3 * Q_ONE / 2, Q_ONE / 2))),
                      coord_t'($urandom_range(Q_ONE / 1365, Q_ONE / 16384)),
                      (mix == MIX_DEEP) ? 32'd255 : 32'($urandom_range(48, 1)));
        end
        MIX_EXTREME: begin
          program_all(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      {8'($urandom), 24'($urandom_range(6))});
        end
        default: begin
          // |c| >= 2 everywhere, so even the largest limit ends after one step
          program_all(flip ? coord_t'(-longint'($urandom_range(8 * Q_ONE, 2 * Q_ONE)))
                           : coord_t'($urandom_range(8 * Q_ONE, 2 * Q_ONE)),
                      flip ? coord_t'(-longint'($urandom_range(1 << 16)))
                           : coord_t'($urandom_range(1 << 16)),
                      coord_t'($urandom), coord_t'($urandom), 32'hffff_ffff);
        end
      endcase
      sender_idle_pct = idle_mix[p % 3];
      fill_random(PHASE_PIXELS);
      drain_requests();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #15ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
src/meiu_pkg.sv
src/meiu_ctrl.sv
src/meiu_datapath.sv
src/mandelbrot_escape_iteration_unit.sv
dv/tb_mandelbrot_escape_iteration_unit.sv
